>>> hw/rtl/m4i_pkg.sv
// shared types, constants and the cofactor term table of the 4x4 matrix inverse unit
// no dependencies; imported by the divider, the top level, the checker and the bench
`timescale 1ns / 1ps

package m4i_pkg;

	localparam int ELEM_W    = 32;          // one matrix element
	localparam int ROW_W     = 4 * ELEM_W;  // one stored matrix row
	localparam int VW        = 100;         // stored minors and signed cofactors
	localparam int AW        = 136;         // accumulator, holds the determinant
	localparam int DW        = AW + 36;     // divider word
	localparam int QW        = 35;          // quotient bits, top bit flags overflow
	localparam int TDATA_W   = 136;         // both stream data buses
	localparam int N_TERMS   = 76;
	localparam int V_DEPTH   = 28;
	localparam logic [4:0] COF_BASE = 5'd12;
	localparam logic [4:0] DET_DST  = 5'd28;
	localparam logic [6:0] LAST_TERM = 7'(N_TERMS - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_MUL,
		ST_ACC,
		ST_ABS,
		ST_SING,
		ST_DRD,
		ST_DSET,
		ST_DSTART,
		ST_DDIV,
		ST_ROW
	} state_t;

	// one multiply-accumulate term: acc +-= element * source
	typedef struct packed {
		logic [3:0] e;      // element index 4*r+c
		logic       sv;     // source is a stored minor or cofactor
		logic [4:0] si;     // source element index or store address
		logic       neg;
		logic       first;
		logic       last;
		logic [4:0] dst;
	} term_t;

	typedef struct packed {
		logic          done;
		logic [QW-1:0] quo;
	} div_res_t;

	function automatic term_t mk(input logic [3:0] e, input logic sv, input logic [4:0] si,
			input logic neg, input logic first, input logic last, input logic [4:0] dst);
		term_t r;
		r.e = e;
		r.sv = sv;
		r.si = si;
		r.neg = neg;
		r.first = first;
		r.last = last;
		r.dst = dst;
		return r;
	endfunction

	// minors b0..b5, a0..a5 at 0..11, signed cofactors at 12..27, determinant last
	function automatic term_t term_rom(input logic [6:0] t);
		term_t r;
		r = '0;
		case (t)
			7'd0:  r = mk(4'd8,  1'b0, 5'd13, 1'b0, 1'b1, 1'b0, 5'd0);
			7'd1:  r = mk(4'd9,  1'b0, 5'd12, 1'b1, 1'b0, 1'b1, 5'd0);
			7'd2:  r = mk(4'd8,  1'b0, 5'd14, 1'b0, 1'b1, 1'b0, 5'd1);
			7'd3:  r = mk(4'd10, 1'b0, 5'd12, 1'b1, 1'b0, 1'b1, 5'd1);
			7'd4:  r = mk(4'd11, 1'b0, 5'd12, 1'b0, 1'b1, 1'b0, 5'd2);
			7'd5:  r = mk(4'd8,  1'b0, 5'd15, 1'b1, 1'b0, 1'b1, 5'd2);
			7'd6:  r = mk(4'd9,  1'b0, 5'd14, 1'b0, 1'b1, 1'b0, 5'd3);
			7'd7:  r = mk(4'd10, 1'b0, 5'd13, 1'b1, 1'b0, 1'b1, 5'd3);
			7'd8:  r = mk(4'd11, 1'b0, 5'd13, 1'b0, 1'b1, 1'b0, 5'd4);
			7'd9:  r = mk(4'd9,  1'b0, 5'd15, 1'b1, 1'b0, 1'b1, 5'd4);
			7'd10: r = mk(4'd10, 1'b0, 5'd15, 1'b0, 1'b1, 1'b0, 5'd5);
			7'd11: r = mk(4'd11, 1'b0, 5'd14, 1'b1, 1'b0, 1'b1, 5'd5);
			7'd12: r = mk(4'd0,  1'b0, 5'd5,  1'b0, 1'b1, 1'b0, 5'd6);
			7'd13: r = mk(4'd1,  1'b0, 5'd4,  1'b1, 1'b0, 1'b1, 5'd6);
			7'd14: r = mk(4'd0,  1'b0, 5'd6,  1'b0, 1'b1, 1'b0, 5'd7);
			7'd15: r = mk(4'd2,  1'b0, 5'd4,  1'b1, 1'b0, 1'b1, 5'd7);
			7'd16: r = mk(4'd3,  1'b0, 5'd4,  1'b0, 1'b1, 1'b0, 5'd8);
			7'd17: r = mk(4'd0,  1'b0, 5'd7,  1'b1, 1'b0, 1'b1, 5'd8);
			7'd18: r = mk(4'd1,  1'b0, 5'd6,  1'b0, 1'b1, 1'b0, 5'd9);
			7'd19: r = mk(4'd2,  1'b0, 5'd5,  1'b1, 1'b0, 1'b1, 5'd9);
			7'd20: r = mk(4'd3,  1'b0, 5'd5,  1'b0, 1'b1, 1'b0, 5'd10);
			7'd21: r = mk(4'd1,  1'b0, 5'd7,  1'b1, 1'b0, 1'b1, 5'd10);
			7'd22: r = mk(4'd2,  1'b0, 5'd7,  1'b0, 1'b1, 1'b0, 5'd11);
			7'd23: r = mk(4'd3,  1'b0, 5'd6,  1'b1, 1'b0, 1'b1, 5'd11);
			// cofactor 0
			7'd24: r = mk(4'd5,  1'b1, 5'd5,  1'b0, 1'b1, 1'b0, 5'd12);
			7'd25: r = mk(4'd6,  1'b1, 5'd4,  1'b0, 1'b0, 1'b0, 5'd12);
			7'd26: r = mk(4'd7,  1'b1, 5'd3,  1'b0, 1'b0, 1'b1, 5'd12);
			// cofactor 1
			7'd27: r = mk(4'd1,  1'b1, 5'd5,  1'b1, 1'b1, 1'b0, 5'd13);
			7'd28: r = mk(4'd2,  1'b1, 5'd4,  1'b1, 1'b0, 1'b0, 5'd13);
			7'd29: r = mk(4'd3,  1'b1, 5'd3,  1'b1, 1'b0, 1'b1, 5'd13);
			// cofactor 2
			7'd30: r = mk(4'd13, 1'b1, 5'd11, 1'b0, 1'b1, 1'b0, 5'd14);
			7'd31: r = mk(4'd14, 1'b1, 5'd10, 1'b0, 1'b0, 1'b0, 5'd14);
			7'd32: r = mk(4'd15, 1'b1, 5'd9,  1'b0, 1'b0, 1'b1, 5'd14);
			// cofactor 3
			7'd33: r = mk(4'd9,  1'b1, 5'd11, 1'b1, 1'b1, 1'b0, 5'd15);
			7'd34: r = mk(4'd10, 1'b1, 5'd10, 1'b1, 1'b0, 1'b0, 5'd15);
			7'd35: r = mk(4'd11, 1'b1, 5'd9,  1'b1, 1'b0, 1'b1, 5'd15);
			// cofactor 4
			7'd36: r = mk(4'd4,  1'b1, 5'd5,  1'b1, 1'b1, 1'b0, 5'd16);
			7'd37: r = mk(4'd6,  1'b1, 5'd2,  1'b1, 1'b0, 1'b0, 5'd16);
			7'd38: r = mk(4'd7,  1'b1, 5'd1,  1'b1, 1'b0, 1'b1, 5'd16);
			// cofactor 5
			7'd39: r = mk(4'd0,  1'b1, 5'd5,  1'b0, 1'b1, 1'b0, 5'd17);
			7'd40: r = mk(4'd2,  1'b1, 5'd2,  1'b0, 1'b0, 1'b0, 5'd17);
			7'd41: r = mk(4'd3,  1'b1, 5'd1,  1'b0, 1'b0, 1'b1, 5'd17);
			// cofactor 6
			7'd42: r = mk(4'd12, 1'b1, 5'd11, 1'b1, 1'b1, 1'b0, 5'd18);
			7'd43: r = mk(4'd14, 1'b1, 5'd8,  1'b1, 1'b0, 1'b0, 5'd18);
			7'd44: r = mk(4'd15, 1'b1, 5'd7,  1'b1, 1'b0, 1'b1, 5'd18);
			// cofactor 7
			7'd45: r = mk(4'd8,  1'b1, 5'd11, 1'b0, 1'b1, 1'b0, 5'd19);
			7'd46: r = mk(4'd10, 1'b1, 5'd8,  1'b0, 1'b0, 1'b0, 5'd19);
			7'd47: r = mk(4'd11, 1'b1, 5'd7,  1'b0, 1'b0, 1'b1, 5'd19);
			// cofactor 8
			7'd48: r = mk(4'd4,  1'b1, 5'd4,  1'b1, 1'b1, 1'b0, 5'd20);
			7'd49: r = mk(4'd5,  1'b1, 5'd2,  1'b0, 1'b0, 1'b0, 5'd20);
			7'd50: r = mk(4'd7,  1'b1, 5'd0,  1'b0, 1'b0, 1'b1, 5'd20);
			// cofactor 9
			7'd51: r = mk(4'd0,  1'b1, 5'd4,  1'b0, 1'b1, 1'b0, 5'd21);
			7'd52: r = mk(4'd1,  1'b1, 5'd2,  1'b1, 1'b0, 1'b0, 5'd21);
			7'd53: r = mk(4'd3,  1'b1, 5'd0,  1'b1, 1'b0, 1'b1, 5'd21);
			// cofactor 10
			7'd54: r = mk(4'd12, 1'b1, 5'd10, 1'b1, 1'b1, 1'b0, 5'd22);
			7'd55: r = mk(4'd13, 1'b1, 5'd8,  1'b0, 1'b0, 1'b0, 5'd22);
			7'd56: r = mk(4'd15, 1'b1, 5'd6,  1'b0, 1'b0, 1'b1, 5'd22);
			// cofactor 11
			7'd57: r = mk(4'd8,  1'b1, 5'd10, 1'b0, 1'b1, 1'b0, 5'd23);
			7'd58: r = mk(4'd9,  1'b1, 5'd8,  1'b1, 1'b0, 1'b0, 5'd23);
			7'd59: r = mk(4'd11, 1'b1, 5'd6,  1'b1, 1'b0, 1'b1, 5'd23);
			// cofactor 12
			7'd60: r = mk(4'd4,  1'b1, 5'd3,  1'b1, 1'b1, 1'b0, 5'd24);
			7'd61: r = mk(4'd5,  1'b1, 5'd1,  1'b0, 1'b0, 1'b0, 5'd24);
			7'd62: r = mk(4'd6,  1'b1, 5'd0,  1'b1, 1'b0, 1'b1, 5'd24);
			// cofactor 13
			7'd63: r = mk(4'd0,  1'b1, 5'd3,  1'b0, 1'b1, 1'b0, 5'd25);
			7'd64: r = mk(4'd1,  1'b1, 5'd1,  1'b1, 1'b0, 1'b0, 5'd25);
			7'd65: r = mk(4'd2,  1'b1, 5'd0,  1'b0, 1'b0, 1'b1, 5'd25);
			// cofactor 14
			7'd66: r = mk(4'd12, 1'b1, 5'd9,  1'b1, 1'b1, 1'b0, 5'd26);
			7'd67: r = mk(4'd13, 1'b1, 5'd7,  1'b0, 1'b0, 1'b0, 5'd26);
			7'd68: r = mk(4'd14, 1'b1, 5'd6,  1'b1, 1'b0, 1'b1, 5'd26);
			// cofactor 15
			7'd69: r = mk(4'd8,  1'b1, 5'd9,  1'b0, 1'b1, 1'b0, 5'd27);
			7'd70: r = mk(4'd9,  1'b1, 5'd7,  1'b1, 1'b0, 1'b0, 5'd27);
			7'd71: r = mk(4'd10, 1'b1, 5'd6,  1'b0, 1'b0, 1'b1, 5'd27);
			// determinant by expansion along row 0
			7'd72: r = mk(4'd0,  1'b1, 5'd12, 1'b0, 1'b1, 1'b0, DET_DST);
			7'd73: r = mk(4'd1,  1'b1, 5'd16, 1'b0, 1'b0, 1'b0, DET_DST);
			7'd74: r = mk(4'd2,  1'b1, 5'd20, 1'b0, 1'b0, 1'b0, DET_DST);
			7'd75: r = mk(4'd3,  1'b1, 5'd24, 1'b0, 1'b0, 1'b1, DET_DST);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/m4i_ram.sv
// generic ram: one write port, two registered read ports
// no dependencies
`timescale 1ns / 1ps

module m4i_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

>>> hw/rtl/m4i_div.sv
// restoring divider, one quotient bit per cycle, top quotient bit flags overflow
// depends on m4i_pkg
`timescale 1ns / 1ps

module m4i_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [m4i_pkg::DW-1:0] num,
	input  logic [m4i_pkg::DW-1:0] den,
	output m4i_pkg::div_res_t    res
);

	import m4i_pkg::*;

	logic [DW-1:0] r_q;
	logic [DW-1:0] ds_q;
	logic [QW-1:0] q_q;
	logic [5:0]    cnt_q;
	logic          done_q;
	logic          ge;

	assign ge = (r_q >= ds_q);

	// iteration counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 6'd1);
			if (start) begin
				cnt_q <= 6'(QW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	// remainder, shifted divisor and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			r_q  <= num;
			ds_q <= den << (QW - 1);
			q_q  <= '0;
		end else if (cnt_q != '0) begin
			if (ge) begin
				r_q <= r_q - ds_q;
			end
			q_q  <= {q_q[QW-2:0], ge};
			ds_q <= ds_q >> 1;
		end
	end

	assign res.done = done_q;
	assign res.quo  = q_q;

endmodule

>>> hw/rtl/matrix4_inverse_unit.sv
// top level of the 4x4 matrix inverse unit, signed fixed point
// depends on m4i_pkg, m4i_ram and m4i_div
`timescale 1ns / 1ps

// Usage
// The matrix enters one row per slave transaction: tdata carries the row
// index and four signed elements. Rows 0 to 2 are only stored; the slave
// side stays ready for the next row. Row 3 is stored and starts the inverse;
// the slave side is not ready until the last result row has been handed to
// the output register. A shared 33x33 multiplier with one wide accumulator
// works through 76 multiply-accumulate terms (minors, cofactors, determinant).
// Each of the 16 quotients then steps through ST_DRD, ST_DSET, ST_DSTART and
// ST_DDIV, waiting on the bit-serial divider; a singular matrix skips the
// division. The master side gives four rows per matrix, out_row 0 to 3, tlast
// on the last, tuser set when the determinant magnitude is zero or below
// det_threshold << 3*FRAC_BITS (all zeros). A stalled receiver holds the
// output register; the sequencer waits for it. Stored rows stay and can be
// reused. det_threshold resets to 7; the user must write it through cfg_we
// and cfg_wdata only while the block is idle; the block does not enforce it.
// Reset clears the sequencer and the output valid; the row store is not
// cleared and must be written before the first row 3 transaction.

module matrix4_inverse_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// row_index[1:0], col0[33:2], col1[65:34], col2[97:66], col3[129:98]
	input  logic [m4i_pkg::TDATA_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// out_row[1:0], inv0[33:2], inv1[65:34], inv2[97:66], inv3[129:98]
	output logic [m4i_pkg::TDATA_W-1:0] m_tdata,
	output logic                      m_tlast,
	// singular[0]
	output logic                      m_tuser,
	input  logic                      cfg_we,
	input  logic [30:0]               cfg_wdata
);

	import m4i_pkg::*;

	localparam int NUM_SHIFT = 2 * FRAC_BITS + 1;
	localparam int THR_SHIFT = 3 * FRAC_BITS;

	state_t state_q, state_d;

	logic [6:0]  t_q;
	logic [1:0]  chunk_q;
	logic [1:0]  row_q;
	logic [1:0]  col_q;
	logic [30:0] thr_q;
	term_t       term;

	logic                  in_accept;
	logic                  out_free;
	logic                  chunk_end;
	logic                  div_start;
	logic                  out_load;

	logic [ROW_W-1:0]      mat_a, mat_b;
	logic [VW-1:0]         v_rdata;
	logic [4:0]            v_raddr;
	logic                  v_we;
	logic                  det_we;

	logic signed [32:0]    e_val, s_val;
	logic [127:0]          v_ext;
	logic [31:0]           e_word, s_word, v_chunk;
	logic signed [65:0]    prod_q;
	logic signed [AW-1:0]  prod_ext, prod_sh, acc_base, acc_next;
	logic signed [AW-1:0]  acc_q, det_q;
	logic [AW-1:0]         dm_q, thr_wide;
	logic                  dneg_q, sing_q;
	logic [VW-1:0]         cmag_q;
	logic                  cneg_q;
	logic [DW-1:0]         div_num, div_den;
	div_res_t              div_res;
	logic [QW-2:0]         mag;
	logic [31:0]           sat;
	logic [31:0]           rowbuf_q [4];

	logic [1:0]            m_row_q;
	logic [31:0]           m_inv_q [4];
	logic                  m_sing_q, m_last_q, m_tvalid_q;

	assign term      = term_rom(t_q);
	assign in_accept = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign chunk_end = !term.sv || (chunk_q == 2'd3);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && s_tdata[1:0] == 2'd3) state_d = ST_RD;
			end
			ST_RD:  state_d = ST_MUL;
			ST_MUL: state_d = ST_ACC;
			ST_ACC: begin
				if (!chunk_end) state_d = ST_MUL;
				else if (t_q == LAST_TERM) state_d = ST_ABS;
				else state_d = ST_RD;
			end
			ST_ABS:    state_d = ST_SING;
			ST_SING:   state_d = ST_DRD;
			ST_DRD:    state_d = sing_q ? ST_ROW : ST_DSET;
			ST_DSET:   state_d = ST_DSTART;
			ST_DSTART: state_d = ST_DDIV;
			ST_DDIV: begin
				if (div_res.done) state_d = (col_q == 2'd3) ? ST_ROW : ST_DRD;
			end
			ST_ROW: begin
				if (out_free) state_d = (row_q == 2'd3) ? ST_IDLE : ST_DRD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		div_start = (state_q == ST_DSTART);
		out_load  = (state_q == ST_ROW) && out_free;
		v_we      = (state_q == ST_ACC) && chunk_end && term.last && (term.dst != DET_DST);
		det_we    = (state_q == ST_ACC) && chunk_end && term.last && (term.dst == DET_DST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// row store, one row per word
	m4i_ram #(.WIDTH(ROW_W), .DEPTH(4)) u_mat (
		.clk     (clk),
		.we      (in_accept),
		.waddr   (s_tdata[1:0]),
		.wdata   (s_tdata[ROW_W+1:2]),
		.raddr_a (term.e[3:2]),
		.rdata_a (mat_a),
		.raddr_b (term.si[3:2]),
		.rdata_b (mat_b)
	);

	// minor and cofactor store
	assign v_raddr = (state_q == ST_DRD || state_q == ST_DSET)
		? COF_BASE + {1'b0, row_q, col_q} : term.si;

	m4i_ram #(.WIDTH(VW), .DEPTH(V_DEPTH)) u_vst (
		.clk     (clk),
		.we      (v_we),
		.waddr   (term.dst),
		.wdata   (acc_next[VW-1:0]),
		.raddr_a (v_raddr),
		.rdata_a (v_rdata),
		.raddr_b (v_raddr),
		.rdata_b ()
	);

	// multiplier operands: element times element or one 32-bit chunk of a stored value
	assign e_word  = mat_a[{term.e[1:0], 5'b0} +: 32];
	assign s_word  = mat_b[{term.si[1:0], 5'b0} +: 32];
	assign v_ext   = {{(128 - VW){v_rdata[VW-1]}}, v_rdata};
	assign v_chunk = v_ext[{chunk_q, 5'b0} +: 32];
	assign e_val   = {e_word[31], e_word};
	assign s_val   = !term.sv ? {s_word[31], s_word}
		: (chunk_q == 2'd3) ? {v_chunk[31], v_chunk} : {1'b0, v_chunk};

	// accumulate the shifted partial product
	assign prod_ext = {{(AW - 66){prod_q[65]}}, prod_q};
	assign prod_sh  = prod_ext << {chunk_q, 5'b0};
	assign acc_base = (term.first && chunk_q == 2'd0) ? '0 : acc_q;
	assign acc_next = term.neg ? acc_base - prod_sh : acc_base + prod_sh;

	assign thr_wide = AW'(thr_q) << THR_SHIFT;

	// divider operands: round to nearest by (2n + d) / 2d
	assign div_num = (DW'(cmag_q) << NUM_SHIFT) + DW'(dm_q);
	assign div_den = DW'(dm_q) << 1;

	m4i_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.res    (div_res)
	);

	// saturate the signed quotient to 32 bits
	assign mag = div_res.quo[QW-2:0];
	always_comb begin
		if (!cneg_q) begin
			sat = (div_res.quo[QW-1] || mag > 34'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
		end else begin
			sat = (div_res.quo[QW-1] || mag > 34'h080000000) ? 32'h80000000
				: ~mag[31:0] + 32'd1;
		end
	end

	// control counters, threshold and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q        <= '0;
			chunk_q    <= '0;
			row_q      <= '0;
			col_q      <= '0;
			thr_q      <= 31'd7;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) thr_q <= cfg_wdata;
			if (state_q == ST_IDLE && in_accept) begin
				t_q     <= '0;
				chunk_q <= '0;
			end
			if (state_q == ST_ACC) begin
				if (!chunk_end) begin
					chunk_q <= chunk_q + 2'd1;
				end else begin
					chunk_q <= '0;
					t_q     <= t_q + 7'd1;
				end
			end
			if (state_q == ST_SING) begin
				row_q <= '0;
				col_q <= '0;
			end
			if (state_q == ST_DDIV && div_res.done) col_q <= col_q + 2'd1;
			if (out_load) row_q <= row_q + 2'd1;
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) prod_q <= e_val * s_val;
		if (state_q == ST_ACC) acc_q <= acc_next;
		if (det_we) det_q <= acc_next;
		if (state_q == ST_ABS) begin
			dm_q   <= det_q[AW-1] ? AW'(-det_q) : det_q;
			dneg_q <= det_q[AW-1];
		end
		if (state_q == ST_SING) sing_q <= (dm_q == '0) || (dm_q < thr_wide);
		if (state_q == ST_DSET) begin
			cmag_q <= v_rdata[VW-1] ? VW'(-$signed(v_rdata)) : v_rdata;
			cneg_q <= v_rdata[VW-1] ^ dneg_q;
		end
		if (state_q == ST_DDIV && div_res.done) rowbuf_q[col_q] <= sat;
		if (out_load) begin
			m_row_q  <= row_q;
			m_sing_q <= sing_q;
			m_last_q <= (row_q == 2'd3);
			for (int i = 0; i < 4; i++) begin
				m_inv_q[i] <= sing_q ? 32'd0 : rowbuf_q[i];
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, m_inv_q[3], m_inv_q[2], m_inv_q[1], m_inv_q[0], m_row_q};
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_sing_q;

endmodule

>>> hw/rtl/m4i_checker.sv
// port-level checks of the 4x4 matrix inverse unit, bound to the top level
// depends on m4i_pkg and matrix4_inverse_unit
`timescale 1ns / 1ps

module m4i_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic [m4i_pkg::TDATA_W-1:0] s_tdata,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [m4i_pkg::TDATA_W-1:0] m_tdata,
	input logic                        m_tlast,
	input logic                        m_tuser
);

	import m4i_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// tlast marks exactly result row 3
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[1:0] == 2'd3)))
		else $error("tlast does not match out_row");

	// a singular matrix gives all-zero elements
	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[129:2] == '0))
		else $error("singular row not zero");

	// row 3 starts the computation and closes the slave side
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[1:0] == 2'd3 |=> !s_tready)
		else $error("ready while computing");

endmodule

bind matrix4_inverse_unit m4i_checker u_chk (.*);

>>> test/matrix4_inverse_unit_tb.sv
// self-checking bench for matrix4_inverse_unit: rows go in on the slave stream, the
// inverse rows come back on the master stream and are compared with an exact predictor
// depends on m4i_pkg and matrix4_inverse_unit
`timescale 1ns / 1ps

module matrix4_inverse_unit_tb;

	import m4i_pkg::*;

	localparam int FRAC = 16;
	localparam int SETTLE_CYCLES = 60;

	typedef logic signed [255:0] wide_t;
	typedef logic [255:0] uwide_t;

	// one row of the inverse as it should appear on the master side
	typedef struct {
		logic [1:0]  row;
		logic [31:0] inv [4];
		logic        singular;
		logic        last;
	} inv_row_t;

	// exact inverse predictor plus queue of pending inverse rows
	class inverse_scoreboard;
		logic [31:0] elem_store [16];
		logic [30:0] threshold;
		inv_row_t    pending_rows [$];
		int          mismatches;
		int          rows_checked;
		int          matrices;
		int          singular_seen;
		int          saturated_seen;

		function new();
			foreach (elem_store[i]) elem_store[i] = '0;
			threshold = 31'd7;
		endfunction

		// rounded quotient c * 2^(2F) / |det|, clipped to 32 bits
		function logic [31:0] scaled_quotient(input wide_t c, input uwide_t dmag, input logic dneg);
			logic   neg;
			uwide_t num;
			uwide_t q;
			neg = c[255] ^ dneg;
			num = (c[255] ? uwide_t'(-c) : uwide_t'(c)) << (2 * FRAC);
			q = ((num << 1) + dmag) / (dmag << 1);
			if (!neg) begin
				if (q > 256'h7FFFFFFF) begin
					saturated_seen++;
					return 32'h7FFFFFFF;
				end
				return q[31:0];
			end
			if (q > 256'h80000000) begin
				saturated_seen++;
				return 32'h80000000;
			end
			return 32'(-q[31:0]);
		endfunction

		// store a row; row 3 queues the four expected inverse rows
		function void note_row(input logic [1:0] row, input logic [31:0] cols [4]);
			wide_t    e [4][4];
			wide_t    b [6];
			wide_t    a [6];
			wide_t    cof [16];
			wide_t    det;
			uwide_t   dmag;
			logic     sing;
			inv_row_t r;
			for (int j = 0; j < 4; j++) elem_store[4 * row + j] = cols[j];
			if (row != 2'd3) return;
			matrices++;
			for (int i = 0; i < 16; i++) e[i / 4][i % 4] = wide_t'($signed(elem_store[i]));
			// 2x2 minors of the lower and upper row pairs
			b[0] = e[2][0] * e[3][1] - e[2][1] * e[3][0];
			b[1] = e[2][0] * e[3][2] - e[2][2] * e[3][0];
			b[2] = e[2][3] * e[3][0] - e[2][0] * e[3][3];
			b[3] = e[2][1] * e[3][2] - e[2][2] * e[3][1];
			b[4] = e[2][3] * e[3][1] - e[2][1] * e[3][3];
			b[5] = e[2][2] * e[3][3] - e[2][3] * e[3][2];
			a[0] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
			a[1] = e[0][0] * e[1][2] - e[0][2] * e[1][0];
			a[2] = e[0][3] * e[1][0] - e[0][0] * e[1][3];
			a[3] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
			a[4] = e[0][3] * e[1][1] - e[0][1] * e[1][3];
			a[5] = e[0][2] * e[1][3] - e[0][3] * e[1][2];
			// unsigned 3x3 cofactors at their inverse positions
			cof[0]  = e[1][1] * b[5] + e[1][2] * b[4] + e[1][3] * b[3];
			cof[4]  = e[1][0] * b[5] + e[1][2] * b[2] + e[1][3] * b[1];
			cof[8]  = -(e[1][0] * b[4]) + e[1][1] * b[2] + e[1][3] * b[0];
			cof[12] = e[1][0] * b[3] - e[1][1] * b[1] + e[1][2] * b[0];
			cof[1]  = e[0][1] * b[5] + e[0][2] * b[4] + e[0][3] * b[3];
			cof[5]  = e[0][0] * b[5] + e[0][2] * b[2] + e[0][3] * b[1];
			cof[9]  = -(e[0][0] * b[4]) + e[0][1] * b[2] + e[0][3] * b[0];
			cof[13] = e[0][0] * b[3] - e[0][1] * b[1] + e[0][2] * b[0];
			cof[2]  = e[3][1] * a[5] + e[3][2] * a[4] + e[3][3] * a[3];
			cof[6]  = e[3][0] * a[5] + e[3][2] * a[2] + e[3][3] * a[1];
			cof[10] = -(e[3][0] * a[4]) + e[3][1] * a[2] + e[3][3] * a[0];
			cof[14] = e[3][0] * a[3] - e[3][1] * a[1] + e[3][2] * a[0];
			cof[3]  = e[2][1] * a[5] + e[2][2] * a[4] + e[2][3] * a[3];
			cof[7]  = e[2][0] * a[5] + e[2][2] * a[2] + e[2][3] * a[1];
			cof[11] = -(e[2][0] * a[4]) + e[2][1] * a[2] + e[2][3] * a[0];
			cof[15] = e[2][0] * a[3] - e[2][1] * a[1] + e[2][2] * a[0];
			det = e[0][0] * cof[0] - e[0][1] * cof[4] + e[0][2] * cof[8] - e[0][3] * cof[12];
			dmag = det[255] ? uwide_t'(-det) : uwide_t'(det);
			sing = (dmag == 0) || (dmag < (uwide_t'(threshold) << (3 * FRAC)));
			if (sing) singular_seen++;
			for (int i = 0; i < 4; i++) begin
				r.row = 2'(i);
				for (int j = 0; j < 4; j++) begin
					r.inv[j] = '0;
					// checkerboard sign of the adjugate
					if (!sing)
						r.inv[j] = scaled_quotient(((i + j) % 2) ? -cof[4 * i + j] : cof[4 * i + j],
							dmag, det[255]);
				end
				r.singular = sing;
				r.last = (i == 3);
				pending_rows.push_back(r);
			end
		endfunction

		// compare one received inverse row with the oldest expected one
		function void check_row(input logic [1:0] row, input logic [31:0] inv [4],
				input logic singular, input logic last);
			inv_row_t x;
			logic     bad;
			rows_checked++;
			if (pending_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t unexpected result row %0d", $realtime, row);
				return;
			end
			x = pending_rows.pop_front();
			bad = (x.row !== row) || (x.singular !== singular) || (x.last !== last);
			for (int j = 0; j < 4; j++) bad |= (x.inv[j] !== inv[j]);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t mismatch exp row %0d %h %h %h %h sing %b last %b",
						$realtime, x.row, x.inv[0], x.inv[1], x.inv[2], x.inv[3],
						x.singular, x.last);
					$display("%0t          got row %0d %h %h %h %h sing %b last %b",
						$realtime, row, inv[0], inv[1], inv[2], inv[3], singular, last);
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;
	logic                m_tlast;
	logic                m_tuser;
	logic                cfg_we;
	logic [30:0]         cfg_wdata;

	inverse_scoreboard sb;
	int  burst_left;
	int  rows_sent;
	int  cfg_writes;
	bit  long_hold_req;

	matrix4_inverse_unit #(.FRAC_BITS(FRAC)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// send one row transaction, then maybe drop valid for a random gap
	task automatic send_row(input logic [1:0] row, input logic [31:0] c0, input logic [31:0] c1,
			input logic [31:0] c2, input logic [31:0] c3);
		logic [31:0] cols [4];
		cols = '{c0, c1, c2, c3};
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, c3, c2, c1, c0, row};
		do @(posedge clk); while (!s_tready);
		sb.note_row(row, cols);
		rows_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 8);
		end
	endtask

	// threshold write, only once the block has gone quiet
	task automatic write_threshold(input logic [30:0] value);
		s_tvalid <= 1'b0;
		while (sb.pending_rows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.threshold = value;
		cfg_writes++;
	endtask

	// random element: full range, moderate Q16.16, or small integer
	function automatic logic [31:0] rand_elem(input int kind);
		case (kind)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
			default: return 32'($signed($urandom_range(0, 8)) - 4) <<< FRAC;
		endcase
	endfunction

	// a full matrix, diagonally boosted most of the time
	task automatic send_random_matrix();
		int kind;
		logic [31:0] v [4];
		kind = $urandom_range(0, 3);
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) v[c] = rand_elem(kind == 3 ? 0 : kind);
			if (kind != 0 && $urandom_range(0, 3) != 0) v[r] = v[r] + (32'h40000 << $urandom_range(0, 2));
			send_row(2'(r), v[0], v[1], v[2], v[3]);
		end
	endtask

	// a few rows in random order, reusing whatever is stored
	task automatic send_loose_rows();
		int n;
		n = $urandom_range(1, 3);
		for (int k = 0; k < n; k++)
			send_row(2'($urandom_range(0, 3)), rand_elem(1), rand_elem(1), rand_elem(0), rand_elem(2));
	endtask

	// receiver: own stall pattern, plus one long hold when asked
	initial begin
		int mode;
		int span;
		m_tready = 1'b0;
		mode = 0;
		span = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				m_tready <= 1'b0;
				repeat (4000) @(posedge clk);
				long_hold_req = 1'b0;
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(20, 200);
				end
				span--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					2: m_tready <= ($urandom_range(0, 4) == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// result transactions
	always @(posedge clk) begin
		logic [31:0] got [4];
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[33:2], m_tdata[65:34], m_tdata[97:66], m_tdata[129:98]};
			sb.check_row(m_tdata[1:0], got, m_tuser, m_tlast);
		end
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	// stimulus and end of run
	initial begin
		sb = new();
		burst_left = 0;
		rows_sent = 0;
		cfg_writes = 0;
		long_hold_req = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity, then a lower triangular matrix with a negative diagonal entry
		send_row(2'd0, 32'h10000, 32'h0, 32'h0, 32'h0);
		send_row(2'd1, 32'h0, 32'h10000, 32'h0, 32'h0);
		send_row(2'd2, 32'h0, 32'h0, 32'h10000, 32'h0);
		send_row(2'd3, 32'h0, 32'h0, 32'h0, 32'h10000);
		send_row(2'd1, 32'h0, 32'hFFFC0000, 32'h0, 32'h0);
		send_row(2'd2, 32'h8000, 32'h0, 32'h30000, 32'h0);
		send_row(2'd3, 32'h0, 32'h0, 32'h0, 32'h20000);
		// row 3 equal to row 0: zero determinant
		send_row(2'd3, 32'h10000, 32'h0, 32'h0, 32'h0);
		// threshold 0: zero determinant still singular, tiny entries saturate both ways
		write_threshold(31'd0);
		send_row(2'd3, 32'h10000, 32'h0, 32'h0, 32'h0);
		send_row(2'd0, 32'h1, 32'h0, 32'h0, 32'h0);
		send_row(2'd1, 32'h0, 32'hFFFFFFFF, 32'h0, 32'h0);
		send_row(2'd2, 32'h0, 32'h0, 32'h1, 32'h0);
		send_row(2'd3, 32'h0, 32'h0, 32'h0, 32'h1);
		// extreme element values
		send_row(2'd0, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h1);
		send_row(2'd1, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h0);
		send_row(2'd2, 32'h0, 32'h1, 32'h7FFFFFFF, 32'h80000000);
		send_row(2'd3, 32'h1, 32'h0, 32'h80000000, 32'h7FFFFFFF);
		// largest threshold: nearly everything singular
		write_threshold(31'h7FFFFFFF);
		send_row(2'd3, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		send_random_matrix();

		// random phases under several thresholds; first one with a long receiver hold
		write_threshold(31'd7);
		long_hold_req = 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 1) write_threshold(31'($urandom_range(0, 32'h100000)));
			if (phase == 2) write_threshold(31'd0);
			if (phase == 3) write_threshold(31'($urandom));
			repeat (13) begin
				if ($urandom_range(0, 5) == 0) send_loose_rows();
				else send_random_matrix();
			end
		end

		s_tvalid <= 1'b0;
		while (sb.pending_rows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d row transactions, %0d inversions (%0d singular)",
			rows_sent, sb.matrices, sb.singular_seen);
		$display("%0d saturated elements, %0d threshold writes, %0d rows checked, %0d mismatches",
			sb.saturated_seen, cfg_writes, sb.rows_checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/m4i_pkg.sv
hw/rtl/m4i_ram.sv
hw/rtl/m4i_div.sv
hw/rtl/matrix4_inverse_unit.sv
hw/rtl/m4i_checker.sv
test/matrix4_inverse_unit_tb.sv
